// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the RTL of the core folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, silent while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, silent while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/vdge_pkg.sv =====
// ----------------------------------------------------------------------------
// vdge_pkg
// Types, constants and the shape table function of the ducking gain core.
// ----------------------------------------------------------------------------
package vdge_pkg;

	localparam int COS_STEPS_DEF = 1024;

	localparam int FRAME_W = 16;
	localparam int POS_W = 16;
	localparam int FACTOR_W = 13;
	localparam int GAIN_W = 9;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [FACTOR_W-1:0] FACTOR_RST = 13'd512;
	localparam logic [POS_W-1:0] FADE_TIME_RST = 16'd26214;

	localparam logic [GAIN_W-1:0] GAIN_UNITY = 9'd256;
	localparam int GAIN_DIV_STEPS = 8;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OVERDRIVE = 1'b0,
		REG_FADE_TIME = 1'b1
	} cfg_reg_t;

	// sin^2(theta) in Q16, theta in Q30, Taylor series to theta^9.
	// Evaluated at elaboration only, to build the shape table.
	function automatic logic [16:0] half_shape_q16(input logic [63:0] theta);
		logic [63:0] th2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] sq;
		th2 = (theta * theta) >> 30;
		sum = theta;
		term = ((theta * th2) >> 30) / 64'd6;
		sum = (sum >= term) ? sum - term : 64'd0;
		term = ((term * th2) >> 30) / 64'd20;
		sum = sum + term;
		term = ((term * th2) >> 30) / 64'd42;
		sum = (sum >= term) ? sum - term : 64'd0;
		term = ((term * th2) >> 30) / 64'd72;
		sum = sum + term;
		if (sum > ONE_Q30) begin
			sum = ONE_Q30;
		end
		sq = (sum * sum) >> 30;
		return 17'((sq + 64'd8192) >> 14);
	endfunction

endpackage

// ===== rtl/core/voice_ducking_gain_envelope_core.sv =====
// ----------------------------------------------------------------------------
// voice_ducking_gain_envelope_core: raised-cosine ducking gain, one tick per frame
// One tick in flight: a new tick is taken only in idle, after the result has moved
// into the output register, which waits while a previous result is still pending.
// The shared restoring divider yields one quotient bit per cycle and is used twice.
// Reset: fade position 0, overdrive 512 (2.0), fade time 26214, no result pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module voice_ducking_gain_envelope_core #(
	parameter int COS_STEPS = vdge_pkg::COS_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vdge_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vdge_pkg::CFG_DATA_W-1:0]     cfg_data,
	// frame tick channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                voice_on,
	input  logic [vdge_pkg::FRAME_W-1:0]        frame_time,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [vdge_pkg::GAIN_W-1:0]         gain,
	output logic [vdge_pkg::POS_W-1:0]          fade_position
);

	// ------------------------------------------------------------------
	// Derived sizes
	// ------------------------------------------------------------------
	localparam int POS_W = vdge_pkg::POS_W;
	// quotient bits of pos * COS_STEPS / fade_time once pos < fade_time
	localparam int QW = $clog2(COS_STEPS);
	// width of the step index, which may reach COS_STEPS itself
	localparam int IW = $clog2(COS_STEPS + 1);
	// width of the scaled numerator pos * COS_STEPS
	localparam int NW = POS_W + IW;
	// shape table covers the first half of the curve, mirrored for the rest
	localparam int HALF = COS_STEPS / 2;
	localparam int AW = $clog2(HALF + 1);
	localparam int GDW = vdge_pkg::GAIN_DIV_STEPS;
	localparam int QUO_W = (QW > GDW) ? QW : GDW;
	localparam int CW = $clog2(QUO_W + 1);

	localparam logic [CW-1:0] IDX_STEPS = CW'(QW);
	localparam logic [CW-1:0] GAIN_STEPS = CW'(GDW);
	localparam logic [IW-1:0] IDX_FULL = IW'(COS_STEPS);
	localparam logic [IW:0] STEPS_X1 = (IW + 1)'(COS_STEPS);
	// 65536 / od with od > 256: start remainder 65536 >> 8, shift in zeros
	localparam logic [POS_W-1:0] GAIN_REM0 = 16'd256;

	typedef enum logic [2:0] {
		S_IDLE,
		S_IDX_SETUP,
		S_IDX_DIV,
		S_ROM,
		S_MUL,
		S_OD,
		S_GAIN_DIV,
		S_FINISH
	} state_t;

	// ------------------------------------------------------------------
	// Configuration registers. A write lands on any cycle; the sender must
	// issue writes only while no tick is in flight, which the block does not enforce.
	// ------------------------------------------------------------------
	logic [vdge_pkg::FACTOR_W-1:0] od_factor_q;
	logic [POS_W-1:0]              fade_time_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			od_factor_q <= vdge_pkg::FACTOR_RST;
			fade_time_q <= vdge_pkg::FADE_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (vdge_pkg::cfg_reg_t'(cfg_index))
				vdge_pkg::REG_OVERDRIVE: od_factor_q <= cfg_data[vdge_pkg::FACTOR_W-1:0];
				vdge_pkg::REG_FADE_TIME: fade_time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Raised-cosine shape table, sin^2 over the first half, built at
	// elaboration. Read through a registered port.
	// ------------------------------------------------------------------
	logic [16:0] shape_rom [HALF+1];

	for (genvar g = 0; g <= HALF; g++) begin : g_shape
		localparam logic [63:0] THETA = (64'(g) * vdge_pkg::PI_Q30) / 64'(2 * COS_STEPS);
		assign shape_rom[g] = vdge_pkg::half_shape_q16(THETA);
	end

	// ------------------------------------------------------------------
	// Sequencer state and datapath registers
	// ------------------------------------------------------------------
	state_t                  state_q;
	logic [POS_W-1:0]        fade_pos_q;   // envelope position, survives between ticks
	logic [IW-1:0]           idx_q;        // step index 0..COS_STEPS
	logic [AW-1:0]           rom_addr;
	logic                    mirror;
	logic                    mirror_q;
	logic [16:0]             half_q;       // registered table read
	logic signed [31:0]      prod_q;       // diff * shape + rounding
	logic [vdge_pkg::FACTOR_W-1:0] od_q;   // interpolated factor, above unity
	logic [vdge_pkg::GAIN_W-1:0]   gain_res_q;
	logic [vdge_pkg::GAIN_W-1:0]   gain_q;
	logic [POS_W-1:0]        pos_out_q;
	logic                    out_valid_q;

	// shared divider
	logic [POS_W-1:0]        rem_q;
	logic [QW-1:0]           lo_q;         // low numerator bits still to shift in
	logic [QUO_W-1:0]        quo_q;
	logic [CW-1:0]           cnt_q;

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign gain          = gain_q;
	assign fade_position = pos_out_q;

	// ------------------------------------------------------------------
	// Position update for the incoming tick: rise toward fade_time while
	// voice is active, fall toward zero otherwise, both saturating.
	// ------------------------------------------------------------------
	logic [POS_W:0]   pos_sum;
	logic [POS_W-1:0] pos_next;

	always_comb begin
		pos_sum = {1'b0, fade_pos_q} + {1'b0, frame_time};
		if (voice_on) begin
			pos_next = (pos_sum < {1'b0, fade_time_q}) ? pos_sum[POS_W-1:0] : fade_time_q;
		end else begin
			pos_next = (fade_pos_q > frame_time) ? fade_pos_q - frame_time : '0;
		end
	end

	// Scaled numerator for the index division (constant multiply).
	logic [NW-1:0] num;
	assign num = NW'(fade_pos_q) * NW'(COS_STEPS);

	// ------------------------------------------------------------------
	// Shared restoring divide step: shift one numerator bit into the
	// remainder, trial-subtract the divisor, keep the difference if it
	// does not borrow. The remainder always stays below the divisor.
	// ------------------------------------------------------------------
	logic [POS_W-1:0] div_sel;
	logic             bit_in;
	logic [POS_W:0]   rem_sh;
	logic [POS_W+1:0] trial;
	logic             ge;
	logic [POS_W-1:0] rem_nx;
	logic [QUO_W-1:0] quo_nx;

	always_comb begin
		div_sel = (state_q == S_GAIN_DIV) ? POS_W'(od_q) : fade_time_q;
		bit_in  = (state_q == S_IDX_DIV) ? lo_q[QW-1] : 1'b0;
		rem_sh  = {rem_q, bit_in};
		trial   = {1'b0, rem_sh} - {2'b00, div_sel};
		ge      = !trial[POS_W+1];
		rem_nx  = ge ? trial[POS_W-1:0] : rem_sh[POS_W-1:0];
		quo_nx  = {quo_q[QUO_W-2:0], ge};
	end

	// Table address: fold the upper half of the curve onto the lower.
	always_comb begin
		mirror   = ({idx_q, 1'b0} > STEPS_X1);
		rom_addr = mirror ? AW'(IDX_FULL - idx_q) : AW'(idx_q);
	end

	// Overdrive interpolation: (factor - 256) * shape, rounded in Q16.
	logic signed [13:0] diff_s;
	logic [16:0]        s16;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [31:0] prod_nx;
	logic signed [13:0] od_full;

	always_comb begin
		diff_s  = signed'({1'b0, od_factor_q}) - 14'sd256;
		s16     = mirror_q ? (17'h10000 - half_q) : half_q;
		mul_a   = 32'(diff_s);
		mul_b   = signed'(32'(s16));
		prod_nx = mul_a * mul_b + 32'sd32768;
		// floor division by 65536 is an arithmetic shift
		od_full = 14'sd256 + 14'(prod_q >>> 16);
	end

	// ------------------------------------------------------------------
	// Sequencer: position update on transfer, index division, table read,
	// multiply, gain division, then hand the result to the output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fade_pos_q  <= '0;
			idx_q       <= '0;
			mirror_q    <= 1'b0;
			half_q      <= '0;
			prod_q      <= '0;
			od_q        <= '0;
			gain_res_q  <= '0;
			gain_q      <= '0;
			pos_out_q   <= '0;
			out_valid_q <= 1'b0;
			rem_q       <= '0;
			lo_q        <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
		end else begin
			// drop the result once the consumer takes it, unless a new one replaces it
			if (out_valid_q && out_ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						fade_pos_q <= pos_next;
						state_q    <= S_IDX_SETUP;
					end
				end

				S_IDX_SETUP: begin
					if (fade_time_q == '0) begin
						// no fade time: step straight to either end
						idx_q   <= (fade_pos_q != '0) ? IDX_FULL : '0;
						state_q <= S_ROM;
					end else if (fade_pos_q >= fade_time_q) begin
						// ratio clamps to one
						idx_q   <= IDX_FULL;
						state_q <= S_ROM;
					end else begin
						rem_q   <= POS_W'(num >> QW);
						lo_q    <= num[QW-1:0];
						quo_q   <= '0;
						cnt_q   <= IDX_STEPS;
						state_q <= S_IDX_DIV;
					end
				end

				S_IDX_DIV: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					lo_q  <= lo_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						idx_q   <= IW'(quo_nx[QW-1:0]);
						state_q <= S_ROM;
					end
				end

				S_ROM: begin
					half_q   <= shape_rom[rom_addr];
					mirror_q <= mirror;
					state_q  <= S_MUL;
				end

				S_MUL: begin
					prod_q  <= prod_nx;
					state_q <= S_OD;
				end

				S_OD: begin
					if (od_full <= 14'sd256) begin
						// factor at or below unity: hold unity gain
						gain_res_q <= vdge_pkg::GAIN_UNITY;
						state_q    <= S_FINISH;
					end else begin
						od_q    <= od_full[vdge_pkg::FACTOR_W-1:0];
						rem_q   <= GAIN_REM0;
						quo_q   <= '0;
						cnt_q   <= GAIN_STEPS;
						state_q <= S_GAIN_DIV;
					end
				end

				S_GAIN_DIV: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						gain_res_q <= {1'b0, quo_nx[GDW-1:0]};
						state_q    <= S_FINISH;
					end
				end

				S_FINISH: begin
					// advance only when the output register is free or being emptied
					if (!out_valid_q || out_ready) begin
						gain_q      <= gain_res_q;
						pos_out_q   <= fade_pos_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ASSERT_NEXT(a_rise_saturates, clk, arst_n, in_valid && in_ready && voice_on, fade_pos_q <= fade_time_q, "fade position above fade time after a voice tick")
	`ASSERT_IMPLIES(a_div_rem_below, clk, arst_n, state_q == S_IDX_DIV || state_q == S_GAIN_DIV, rem_q < div_sel, "divider remainder not below divisor")
	`ASSERT_IMPLIES(a_gain_range, clk, arst_n, out_valid, gain <= vdge_pkg::GAIN_UNITY, "gain above unity")
	`ASSERT_IMPLIES(a_rest_unity, clk, arst_n, out_valid && fade_position == '0, gain == vdge_pkg::GAIN_UNITY, "gain not unity at rest position")

endmodule
